[design/bcopen_pkg.sv]
package bcopen_pkg;

   // Line store geometry
   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);

   // Register and counter widths
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 16;
   localparam int ROW_W    = HEIGHT_W + 1;
   localparam int CSR_W    = HEIGHT_W;

   // Clamp limits of the frame size registers
   localparam logic [WIDTH_W-1:0]  MIN_WIDTH   = WIDTH_W'(3);
   localparam logic [WIDTH_W-1:0]  MAX_WIDTH_V = WIDTH_W'(MAX_WIDTH);
   localparam logic [HEIGHT_W-1:0] MIN_HEIGHT  = HEIGHT_W'(3);

   // Register reset values
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

   // Register indexes
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // Request kinds
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   // Foreground gray level
   localparam logic [7:0] FG_LEVEL = 8'd255;

   // One line store entry: bit 0 older row, bit 1 newer row
   typedef logic [1:0] line_type;

   // Access bundle of one line store
   typedef struct packed {
      logic             write_enable;
      logic [COL_W-1:0] write_addr;
      line_type         write_data;
      logic [COL_W-1:0] read_addr_a;
      logic [COL_W-1:0] read_addr_b;
   } store_req_type;

endpackage

[design/bcopen_line_store.sv]
module bcopen_line_store (
   input  logic                      clock,
   input  bcopen_pkg::store_req_type req,
   output bcopen_pkg::line_type      rd_data_a,
   output bcopen_pkg::line_type      rd_data_b
);
   import bcopen_pkg::*;

   line_type mem [MAX_WIDTH];
   line_type rd_a_ff;
   line_type rd_b_ff;

   // One write port, two registered read ports
   always_ff @(posedge clock) begin
      if (req.write_enable) begin
         mem[req.write_addr] <= req.write_data;
      end
      rd_a_ff <= mem[req.read_addr_a];
      rd_b_ff <= mem[req.read_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[design/binary_cross_opening_3x3_unit.sv]
// Streaming binary opening (erode, then dilate) with a 3x3 cross element.
// One request per clock is taken while req_stall is low, and each request
// at row r, column c gives the opened pixel of row r-2, column c, so results
// lag the input by two rows: a frame is image_height pixel rows followed by
// two rows of flush requests, and requests in rows 0 and 1 give no result.
// The last result of a frame carries last_of_frame. Both stages keep two
// rows per column in a 1024 x 2 line store; each store is read at the next
// column and the one after it ahead of use, so the registered read latency
// is hidden and the rate of one request per cycle holds while not stalled.
// A two-entry output buffer lets a request through while one result waits. No clearing pass: the stores need none.
module binary_cross_opening_3x3_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic                          csr_index,
   input  logic [bcopen_pkg::CSR_W-1:0]  csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [7:0]                    req_pixel_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_opened_pixel,
   output logic                          rsp_last_of_frame
);
   import bcopen_pkg::*;

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                in_left_ff, in_left_in;
   logic                er_left_ff, er_left_in;
   logic                out_vld_ff, out_vld_in;
   logic                out_pix_ff, out_pix_in;
   logic                out_last_ff, out_last_in;
   logic                skid_vld_ff, skid_vld_in;
   logic                skid_pix_ff, skid_pix_in;
   logic                skid_last_ff, skid_last_in;

   logic [WIDTH_W-1:0]  w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [WIDTH_W-1:0]  col_ext;
   logic [ROW_W-1:0]    h_ext;
   logic                accept;
   logic                last_col, last_row, inside_col;
   logic                er_row, op_row, has_result;
   logic [COL_W-1:0]    next_col, read_col;
   logic                x_bit, er_bit, op_bit, frame_end;
   logic [4:0]          in_taps, er_taps;
   line_type            in_rd_a, in_rd_b, er_rd_a, er_rd_b;
   store_req_type       in_req, er_req;
   logic                main_free;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wen) begin
         if (csr_index == CSR_IMAGE_WIDTH) begin
            width_ff <= csr_wdata[WIDTH_W-1:0];
         end else begin
            height_ff <= csr_wdata[HEIGHT_W-1:0];
         end
      end
   end

   // Clamp the frame size
   always_comb begin
      if (width_ff < MIN_WIDTH) begin
         w_eff = MIN_WIDTH;
      end else if (width_ff > MAX_WIDTH_V) begin
         w_eff = MAX_WIDTH_V;
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff < MIN_HEIGHT) ? MIN_HEIGHT : height_ff;
   end

   // Position decode
   assign accept     = req_valid & ~req_stall;
   assign col_ext    = {{(WIDTH_W-COL_W){1'b0}}, col_ff};
   assign h_ext      = {1'b0, h_eff};
   assign last_col   = (col_ext + WIDTH_W'(1)) >= w_eff;
   assign last_row   = row_ff >= (h_ext + ROW_W'(1));
   assign inside_col = (col_ff != '0) && ((col_ext + WIDTH_W'(2)) <= w_eff);
   assign er_row     = (row_ff >= ROW_W'(2)) && (row_ff <= (h_ext - ROW_W'(1)));
   assign op_row     = (row_ff >= ROW_W'(3)) && (row_ff <= h_ext);
   assign has_result = row_ff >= ROW_W'(2);
   assign frame_end  = last_col & last_row;
   assign next_col   = last_col ? '0 : col_ff + COL_W'(1);

   // Prefetch the column of the next request and its right neighbor
   assign read_col = accept ? next_col : col_ff;

   // Erosion: center at row r-1, all five cross taps set
   assign x_bit   = (req_func == FUNC_PIXEL) && (req_pixel_value == FG_LEVEL);
   assign in_taps = {x_bit, in_rd_a[1], in_rd_b[1], in_left_ff, in_rd_b[0]};
   assign er_bit  = inside_col & er_row & (&in_taps);

   // Dilation: center at row r-2, any cross tap set
   assign er_taps = {er_bit, er_rd_a[1], er_rd_b[1], er_left_ff, er_rd_b[0]};
   assign op_bit  = inside_col & op_row & (|er_taps);

   // Write back the current column; reads never hit the written column
   always_comb begin
      in_req.write_enable = accept;
      in_req.write_addr   = col_ff;
      in_req.write_data   = {x_bit, in_rd_b[1]};
      in_req.read_addr_a  = read_col + COL_W'(1);
      in_req.read_addr_b  = read_col;
      er_req              = in_req;
      er_req.write_data   = {er_bit, er_rd_b[1]};
   end

   bcopen_line_store u_in_store (
      .clock     (clock),
      .req       (in_req),
      .rd_data_a (in_rd_a),
      .rd_data_b (in_rd_b)
   );

   bcopen_line_store u_er_store (
      .clock     (clock),
      .req       (er_req),
      .rd_data_a (er_rd_a),
      .rd_data_b (er_rd_b)
   );

   // Advance position and left taps
   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      in_left_in = in_left_ff;
      er_left_in = er_left_ff;
      if (accept) begin
         col_in     = next_col;
         in_left_in = in_rd_b[1];
         er_left_in = er_rd_b[1];
         if (last_col) begin
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end
      end
   end

   // Output register with skid entry
   always_comb begin
      main_free    = ~out_vld_ff | ~rsp_stall;
      out_vld_in   = out_vld_ff;
      out_pix_in   = out_pix_ff;
      out_last_in  = out_last_ff;
      skid_vld_in  = skid_vld_ff;
      skid_pix_in  = skid_pix_ff;
      skid_last_in = skid_last_ff;
      if (main_free) begin
         if (skid_vld_ff) begin
            out_vld_in   = 1'b1;
            out_pix_in   = skid_pix_ff;
            out_last_in  = skid_last_ff;
            skid_vld_in  = accept & has_result;
            skid_pix_in  = op_bit;
            skid_last_in = frame_end;
         end else begin
            out_vld_in  = accept & has_result;
            out_pix_in  = op_bit;
            out_last_in = frame_end;
         end
      end else if (accept & has_result) begin
         skid_vld_in  = 1'b1;
         skid_pix_in  = op_bit;
         skid_last_in = frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         in_left_ff  <= 1'b0;
         er_left_ff  <= 1'b0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         in_left_ff  <= in_left_in;
         er_left_ff  <= er_left_in;
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   // Payload holds without reset
   always_ff @(posedge clock) begin
      out_pix_ff   <= out_pix_in;
      out_last_ff  <= out_last_in;
      skid_pix_ff  <= skid_pix_in;
      skid_last_ff <= skid_last_in;
   end

   assign req_stall         = skid_vld_ff;
   assign rsp_valid         = out_vld_ff;
   assign rsp_opened_pixel  = out_pix_ff;
   assign rsp_last_of_frame = out_last_ff;

   // Skid entry only fills behind a held result
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid entry valid without a held result");

   // Frame end returns to the origin
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && frame_end) |=> (row_ff == '0 && col_ff == '0))
      else $error("position not cleared at frame end");

   // Row end steps one row down
   a_row_step: assert property (@(posedge clock) disable iff (reset)
      (accept && last_col && !last_row) |=>
         (col_ff == '0 && row_ff == $past(row_ff) + ROW_W'(1)))
      else $error("row not advanced at row end");

endmodule
